// ===== rtl/ec_pkg.sv =====
// Shared constants and control bundle for the elastic disk collision pipeline.
`timescale 1ns / 1ps

package ec_pkg;

  localparam int EC_COORD_WIDTH = 24;
  localparam int EC_MASS_WIDTH  = 16;

  // Control that travels with every pipeline slot.
  typedef struct packed {
    logic vld;
    logic hit;
    logic neg_x;
    logic neg_y;
  } ec_ctl_t;

endpackage

// ===== rtl/elastic_disk_collision.sv =====
// Top level: 2D elastic collision response of two disks, fully pipelined.
`timescale 1ns / 1ps

//  channel   ports                                   transfer
//  ------    -------------------------------------   ---------------------------------
//  input     start, busy, in_pos_*, in_vel_*,         edge with start high, busy low
//            in_radius_*, in_mass_*
//  result    out_strobe, out_new_vel_*, out_collided  edge ending the out_strobe cycle
//
//  One pair enters per clock; the result passes 3 geometry stages, 4 product
//  stages, one divider stage per quotient bit (COORD_WIDTH + 2) and one output stage.
//  The divider chain sets the latency; throughput is one pair per cycle.
//  busy stays low: the receiver cannot stall, so nothing holds the pipe.
//  Synchronous active-low reset clears only the valid bits and control bundles.

module elastic_disk_collision #(
  parameter int COORD_WIDTH = ec_pkg::EC_COORD_WIDTH,
  parameter int MASS_WIDTH  = ec_pkg::EC_MASS_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] in_pos_a_x,
  input  logic [COORD_WIDTH-1:0] in_pos_a_y,
  input  logic [COORD_WIDTH-1:0] in_pos_b_x,
  input  logic [COORD_WIDTH-1:0] in_pos_b_y,
  input  logic [COORD_WIDTH-1:0] in_vel_a_x,
  input  logic [COORD_WIDTH-1:0] in_vel_a_y,
  input  logic [COORD_WIDTH-1:0] in_vel_b_x,
  input  logic [COORD_WIDTH-1:0] in_vel_b_y,
  input  logic [COORD_WIDTH-2:0] in_radius_a,
  input  logic [COORD_WIDTH-2:0] in_radius_b,
  input  logic [MASS_WIDTH-1:0]  in_mass_a,
  input  logic [MASS_WIDTH-1:0]  in_mass_b,
  output logic                   out_strobe,
  output logic [COORD_WIDTH-1:0] out_new_vel_a_x,
  output logic [COORD_WIDTH-1:0] out_new_vel_a_y,
  output logic [COORD_WIDTH-1:0] out_new_vel_b_x,
  output logic [COORD_WIDTH-1:0] out_new_vel_b_y,
  output logic                   out_collided
);
  import ec_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = MASS_WIDTH;
  localparam int NW   = 3*CW + MW + 2;
  localparam int DENW = 2*CW + MW + 2;
  localparam int QW   = CW + 2;
  localparam int SW   = CW + 3;

  logic [3:0][CW-1:0] vel_in;
  ec_ctl_t            g_ctl, m_ctl, d_ctl;
  logic [3:0][CW-1:0] g_vel, m_vel, d_vel;
  logic [2*CW:0]      g_dot_mag, g_d2;
  logic [CW-1:0]      g_dpx_mag, g_dpy_mag;
  logic [MW:0]        g_msum, g_ma2, g_mb2;
  logic [3:0][NW-1:0] m_num;
  logic [DENW-1:0]    m_den;
  logic [3:0][QW-1:0] d_quo;

  logic [3:0][CW-1:0] res_nxt, res_r;
  logic               strobe_r, coll_r;

  function automatic logic [CW-1:0] sat_fn(input logic [SW-1:0] s);
    if (!s[SW-1] && (|s[SW-2:CW-1])) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (s[SW-1] && !(&s[SW-2:CW-1])) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return s[CW-1:0];
    end
  endfunction

  assign busy   = 1'b0;
  assign vel_in = {in_vel_b_y, in_vel_b_x, in_vel_a_y, in_vel_a_x};

  ec_geom #(.CW(CW), .MW(MW)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start & ~busy),
    .pos_a_x   (in_pos_a_x),
    .pos_a_y   (in_pos_a_y),
    .pos_b_x   (in_pos_b_x),
    .pos_b_y   (in_pos_b_y),
    .vel_i     (vel_in),
    .radius_a  (in_radius_a),
    .radius_b  (in_radius_b),
    .mass_a    (in_mass_a),
    .mass_b    (in_mass_b),
    .ctl_o     (g_ctl),
    .vel_o     (g_vel),
    .dot_mag_o (g_dot_mag),
    .d2_o      (g_d2),
    .dpx_mag_o (g_dpx_mag),
    .dpy_mag_o (g_dpy_mag),
    .msum_o    (g_msum),
    .ma2_o     (g_ma2),
    .mb2_o     (g_mb2)
  );

  ec_mult #(.CW(CW), .MW(MW)) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (g_ctl),
    .vel_i     (g_vel),
    .dot_mag_i (g_dot_mag),
    .d2_i      (g_d2),
    .dpx_mag_i (g_dpx_mag),
    .dpy_mag_i (g_dpy_mag),
    .msum_i    (g_msum),
    .ma2_i     (g_ma2),
    .mb2_i     (g_mb2),
    .ctl_o     (m_ctl),
    .vel_o     (m_vel),
    .num_o     (m_num),
    .den_o     (m_den)
  );

  ec_div #(.CW(CW), .MW(MW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (m_ctl),
    .vel_i (m_vel),
    .num_i (m_num),
    .den_i (m_den),
    .ctl_o (d_ctl),
    .vel_o (d_vel),
    .quo_o (d_quo)
  );

  // disk A moves against the signed change, disk B with it
  always_comb begin
    logic [SW-1:0] v_ext;
    logic [SW-1:0] q_ext;
    logic [SW-1:0] sum;
    logic          neg;
    logic          plus;
    for (int c = 0; c < 4; c++) begin
      v_ext = {{3{d_vel[c][CW-1]}}, d_vel[c]};
      q_ext = {1'b0, d_quo[c]};
      neg   = c[0] ? d_ctl.neg_y : d_ctl.neg_x;
      plus  = (c < 2) ? neg : ~neg;
      sum   = plus ? (v_ext + q_ext) : (v_ext - q_ext);
      res_nxt[c] = d_ctl.hit ? sat_fn(sum) : d_vel[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= d_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    coll_r <= d_ctl.hit;
  end

  assign out_strobe      = strobe_r;
  assign out_new_vel_a_x = res_r[0];
  assign out_new_vel_a_y = res_r[1];
  assign out_new_vel_b_x = res_r[2];
  assign out_new_vel_b_y = res_r[3];
  assign out_collided    = coll_r;

endmodule

// ===== rtl/ec_geom.sv =====
// Geometry stages: differences, squares, dot product and contact test.
`timescale 1ns / 1ps

module ec_geom #(
  parameter int CW = ec_pkg::EC_COORD_WIDTH,
  parameter int MW = ec_pkg::EC_MASS_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [CW-1:0]      pos_a_x,
  input  logic [CW-1:0]      pos_a_y,
  input  logic [CW-1:0]      pos_b_x,
  input  logic [CW-1:0]      pos_b_y,
  input  logic [3:0][CW-1:0] vel_i,
  input  logic [CW-2:0]      radius_a,
  input  logic [CW-2:0]      radius_b,
  input  logic [MW-1:0]      mass_a,
  input  logic [MW-1:0]      mass_b,
  output ec_pkg::ec_ctl_t    ctl_o,
  output logic [3:0][CW-1:0] vel_o,
  output logic [2*CW:0]      dot_mag_o,
  output logic [2*CW:0]      d2_o,
  output logic [CW-1:0]      dpx_mag_o,
  output logic [CW-1:0]      dpy_mag_o,
  output logic [MW:0]        msum_o,
  output logic [MW:0]        ma2_o,
  output logic [MW:0]        mb2_o
);
  import ec_pkg::*;

  // stage 1
  logic                     vld1_r;
  logic signed [CW:0]       dpx1_nxt, dpy1_nxt, dvx1_nxt, dvy1_nxt;
  logic signed [CW:0]       dpx1_r, dpy1_r, dvx1_r, dvy1_r;
  logic [CW-1:0]            rsum1_nxt, rsum1_r;
  logic [MW-1:0]            ma1_r, mb1_r;
  logic [3:0][CW-1:0]       vel1_r;

  // stage 2
  logic                     vld2_r;
  logic signed [2*CW+1:0]   sqx2_nxt, sqy2_nxt, pdx2_nxt, pdy2_nxt;
  logic [2*CW-1:0]          sqx2_r, sqy2_r;
  logic signed [2*CW:0]     pdx2_r, pdy2_r;
  logic [2*CW-1:0]          rs2_2_nxt, rs2_2_r;
  logic signed [CW:0]       dpx_neg_v, dpy_neg_v;
  logic [CW-1:0]            dpx_mag2_nxt, dpy_mag2_nxt, dpx_mag2_r, dpy_mag2_r;
  logic                     sgnx2_r, sgny2_r, nz2_r;
  logic [MW:0]              msum2_nxt, msum2_r, ma2_2_r, mb2_2_r;
  logic [3:0][CW-1:0]       vel2_r;

  // stage 3
  logic [2*CW:0]            d2_nxt, d2_r;
  logic signed [2*CW+1:0]   dot_nxt, dot_abs_v;
  logic                     dot_neg;
  logic [2*CW:0]            dot_mag_nxt, dot_mag_r;
  ec_ctl_t                  ctl3_nxt, ctl3_r;
  logic [CW-1:0]            dpx_mag3_r, dpy_mag3_r;
  logic [MW:0]              msum3_r, ma2_3_r, mb2_3_r;
  logic [3:0][CW-1:0]       vel3_r;

  assign dpx1_nxt  = $signed({pos_a_x[CW-1], pos_a_x}) - $signed({pos_b_x[CW-1], pos_b_x});
  assign dpy1_nxt  = $signed({pos_a_y[CW-1], pos_a_y}) - $signed({pos_b_y[CW-1], pos_b_y});
  assign dvx1_nxt  = $signed({vel_i[0][CW-1], vel_i[0]}) - $signed({vel_i[2][CW-1], vel_i[2]});
  assign dvy1_nxt  = $signed({vel_i[1][CW-1], vel_i[1]}) - $signed({vel_i[3][CW-1], vel_i[3]});
  assign rsum1_nxt = {1'b0, radius_a} + {1'b0, radius_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      ctl3_r <= '0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      ctl3_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dpx1_r  <= dpx1_nxt;
    dpy1_r  <= dpy1_nxt;
    dvx1_r  <= dvx1_nxt;
    dvy1_r  <= dvy1_nxt;
    rsum1_r <= rsum1_nxt;
    ma1_r   <= mass_a;
    mb1_r   <= mass_b;
    vel1_r  <= vel_i;
  end

  assign sqx2_nxt     = dpx1_r * dpx1_r;
  assign sqy2_nxt     = dpy1_r * dpy1_r;
  assign pdx2_nxt     = dpx1_r * dvx1_r;
  assign pdy2_nxt     = dpy1_r * dvy1_r;
  assign rs2_2_nxt    = rsum1_r * rsum1_r;
  assign dpx_neg_v    = -dpx1_r;
  assign dpy_neg_v    = -dpy1_r;
  assign dpx_mag2_nxt = dpx1_r[CW] ? dpx_neg_v[CW-1:0] : dpx1_r[CW-1:0];
  assign dpy_mag2_nxt = dpy1_r[CW] ? dpy_neg_v[CW-1:0] : dpy1_r[CW-1:0];
  assign msum2_nxt    = {1'b0, ma1_r} + {1'b0, mb1_r};

  always_ff @(posedge clk) begin
    sqx2_r     <= sqx2_nxt[2*CW-1:0];
    sqy2_r     <= sqy2_nxt[2*CW-1:0];
    pdx2_r     <= pdx2_nxt[2*CW:0];
    pdy2_r     <= pdy2_nxt[2*CW:0];
    rs2_2_r    <= rs2_2_nxt;
    dpx_mag2_r <= dpx_mag2_nxt;
    dpy_mag2_r <= dpy_mag2_nxt;
    sgnx2_r    <= dpx1_r[CW];
    sgny2_r    <= dpy1_r[CW];
    nz2_r      <= (|dpx1_r) || (|dpy1_r);
    msum2_r    <= msum2_nxt;
    ma2_2_r    <= {ma1_r, 1'b0};
    mb2_2_r    <= {mb1_r, 1'b0};
    vel2_r     <= vel1_r;
  end

  assign d2_nxt      = {1'b0, sqx2_r} + {1'b0, sqy2_r};
  assign dot_nxt     = $signed({pdx2_r[2*CW], pdx2_r}) + $signed({pdy2_r[2*CW], pdy2_r});
  assign dot_neg     = dot_nxt[2*CW+1];
  assign dot_abs_v   = -dot_nxt;
  assign dot_mag_nxt = dot_neg ? dot_abs_v[2*CW:0] : dot_nxt[2*CW:0];

  // touching, not separating, distinct centers, nonzero total mass
  always_comb begin
    ctl3_nxt.vld   = vld2_r;
    ctl3_nxt.hit   = nz2_r && (msum2_r != '0) && (d2_nxt <= {1'b0, rs2_2_r})
                     && (dot_neg || (dot_nxt == '0));
    ctl3_nxt.neg_x = dot_neg ^ sgnx2_r;
    ctl3_nxt.neg_y = dot_neg ^ sgny2_r;
  end

  always_ff @(posedge clk) begin
    d2_r       <= d2_nxt;
    dot_mag_r  <= dot_mag_nxt;
    dpx_mag3_r <= dpx_mag2_r;
    dpy_mag3_r <= dpy_mag2_r;
    msum3_r    <= msum2_r;
    ma2_3_r    <= ma2_2_r;
    mb2_3_r    <= mb2_2_r;
    vel3_r     <= vel2_r;
  end

  assign ctl_o     = ctl3_r;
  assign vel_o     = vel3_r;
  assign dot_mag_o = dot_mag_r;
  assign d2_o      = d2_r;
  assign dpx_mag_o = dpx_mag3_r;
  assign dpy_mag_o = dpy_mag3_r;
  assign msum_o    = msum3_r;
  assign ma2_o     = ma2_3_r;
  assign mb2_o     = mb2_3_r;

endmodule

// ===== rtl/ec_mult.sv =====
// Product stages: numerators and the shared denominator, split into partial products.
`timescale 1ns / 1ps

module ec_mult #(
  parameter int CW = ec_pkg::EC_COORD_WIDTH,
  parameter int MW = ec_pkg::EC_MASS_WIDTH,
  localparam int NW   = 3*CW + MW + 2,
  localparam int DENW = 2*CW + MW + 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ec_pkg::ec_ctl_t     ctl_i,
  input  logic [3:0][CW-1:0]  vel_i,
  input  logic [2*CW:0]       dot_mag_i,
  input  logic [2*CW:0]       d2_i,
  input  logic [CW-1:0]       dpx_mag_i,
  input  logic [CW-1:0]       dpy_mag_i,
  input  logic [MW:0]         msum_i,
  input  logic [MW:0]         ma2_i,
  input  logic [MW:0]         mb2_i,
  output ec_pkg::ec_ctl_t     ctl_o,
  output logic [3:0][CW-1:0]  vel_o,
  output logic [3:0][NW-1:0]  num_o,
  output logic [DENW-1:0]     den_o
);
  import ec_pkg::*;

  localparam int BW = 3*CW + 1;

  ec_ctl_t                    ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  logic [3:0][CW-1:0]         vel4_r, vel5_r, vel6_r, vel7_r;

  // stage 4: halves of |dot| and |dp|^2 times |dp_c| and the mass sum
  logic [1:0][2*CW:0]         bl_nxt, bl4_r;
  logic [1:0][2*CW-1:0]       bh_nxt, bh4_r;
  logic [CW+MW+1:0]           dl_nxt, dl4_r;
  logic [CW+MW:0]             dh_nxt, dh4_r;
  logic [MW:0]                ma2_4_r, mb2_4_r, ma2_5_r, mb2_5_r;

  // stage 5
  logic [1:0][BW-1:0]         base_nxt, base5_r;
  logic [DENW-1:0]            den_nxt, den5_r, den6_r, den7_r;

  // stage 6 / 7
  logic [3:0][CW+MW+1:0]      p0_nxt, p0_6_r;
  logic [3:0][CW+MW:0]        p1_nxt, p1_6_r, p2_nxt, p2_6_r;
  logic [3:0][NW-1:0]         num_nxt, num7_r;

  assign bl_nxt[0] = dot_mag_i[CW:0] * dpx_mag_i;
  assign bl_nxt[1] = dot_mag_i[CW:0] * dpy_mag_i;
  assign bh_nxt[0] = dot_mag_i[2*CW:CW+1] * dpx_mag_i;
  assign bh_nxt[1] = dot_mag_i[2*CW:CW+1] * dpy_mag_i;
  assign dl_nxt    = d2_i[CW:0] * msum_i;
  assign dh_nxt    = d2_i[2*CW:CW+1] * msum_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      base_nxt[i] = (BW'(bh4_r[i]) << (CW + 1)) + BW'(bl4_r[i]);
    end
    den_nxt = (DENW'(dh4_r) << (CW + 1)) + DENW'(dl4_r);
  end

  // lanes: 0 a_x, 1 a_y (times 2*mass_b); 2 b_x, 3 b_y (times 2*mass_a)
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      p0_nxt[c] = base5_r[c[0]][CW:0]       * ((c < 2) ? mb2_5_r : ma2_5_r);
      p1_nxt[c] = base5_r[c[0]][2*CW:CW+1]  * ((c < 2) ? mb2_5_r : ma2_5_r);
      p2_nxt[c] = base5_r[c[0]][3*CW:2*CW+1] * ((c < 2) ? mb2_5_r : ma2_5_r);
      num_nxt[c] = (NW'(p2_6_r[c]) << (2*CW + 1)) + (NW'(p1_6_r[c]) << (CW + 1))
                   + NW'(p0_6_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
    end else begin
      ctl4_r <= ctl_i;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    vel4_r  <= vel_i;
    vel5_r  <= vel4_r;
    vel6_r  <= vel5_r;
    vel7_r  <= vel6_r;
    bl4_r   <= bl_nxt;
    bh4_r   <= bh_nxt;
    dl4_r   <= dl_nxt;
    dh4_r   <= dh_nxt;
    ma2_4_r <= ma2_i;
    mb2_4_r <= mb2_i;
    ma2_5_r <= ma2_4_r;
    mb2_5_r <= mb2_4_r;
    base5_r <= base_nxt;
    den5_r  <= den_nxt;
    den6_r  <= den5_r;
    den7_r  <= den6_r;
    p0_6_r  <= p0_nxt;
    p1_6_r  <= p1_nxt;
    p2_6_r  <= p2_nxt;
    num7_r  <= num_nxt;
  end

  assign ctl_o = ctl7_r;
  assign vel_o = vel7_r;
  assign num_o = num7_r;
  assign den_o = den7_r;

endmodule

// ===== rtl/ec_div.sv =====
// Pipelined restoring divider: four quotients over one denominator, one bit per stage.
`timescale 1ns / 1ps

module ec_div #(
  parameter int CW = ec_pkg::EC_COORD_WIDTH,
  parameter int MW = ec_pkg::EC_MASS_WIDTH,
  localparam int NW   = 3*CW + MW + 2,
  localparam int DENW = 2*CW + MW + 2,
  localparam int QW   = CW + 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ec_pkg::ec_ctl_t     ctl_i,
  input  logic [3:0][CW-1:0]  vel_i,
  input  logic [3:0][NW-1:0]  num_i,
  input  logic [DENW-1:0]     den_i,
  output ec_pkg::ec_ctl_t     ctl_o,
  output logic [3:0][CW-1:0]  vel_o,
  output logic [3:0][QW-1:0]  quo_o
);
  import ec_pkg::*;

  localparam int NW1 = NW + 1;

  ec_ctl_t               ctl_r   [QW];
  logic [3:0][CW-1:0]    vel_r   [QW];
  logic [3:0][NW-1:0]    rem_r   [QW];
  logic [DENW-1:0]       den_r   [QW];
  logic [3:0][QW-1:0]    q_r     [QW];

  ec_ctl_t               ctl_in  [QW];
  logic [3:0][CW-1:0]    vel_in  [QW];
  logic [3:0][NW-1:0]    rem_in  [QW];
  logic [DENW-1:0]       den_in  [QW];
  logic [3:0][QW-1:0]    q_in    [QW];
  logic [3:0][NW-1:0]    rem_nxt [QW];
  logic [3:0][QW-1:0]    q_nxt   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    // stage k settles quotient bit QW-1-k; the bound on the quotient keeps it below 2^QW
    localparam int SH = QW - 1 - k;

    if (k == 0) begin : g_first
      assign ctl_in[k] = ctl_i;
      assign vel_in[k] = vel_i;
      assign rem_in[k] = num_i;
      assign den_in[k] = den_i;
      assign q_in[k]   = '0;
    end else begin : g_next
      assign ctl_in[k] = ctl_r[k-1];
      assign vel_in[k] = vel_r[k-1];
      assign rem_in[k] = rem_r[k-1];
      assign den_in[k] = den_r[k-1];
      assign q_in[k]   = q_r[k-1];
    end

    always_comb begin
      logic [NW:0] trial;
      for (int c = 0; c < 4; c++) begin
        trial = {1'b0, rem_in[k][c]} - (NW1'(den_in[k]) << SH);
        rem_nxt[k][c] = trial[NW] ? rem_in[k][c] : trial[NW-1:0];
        q_nxt[k][c]   = {q_in[k][c][QW-2:0], ~trial[NW]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_in[k];
      end
    end

    always_ff @(posedge clk) begin
      vel_r[k] <= vel_in[k];
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_in[k];
      q_r[k]   <= q_nxt[k];
    end
  end

  assign ctl_o = ctl_r[QW-1];
  assign vel_o = vel_r[QW-1];
  assign quo_o = q_r[QW-1];

endmodule
